### design/sarf_pkg.sv
// sarf_pkg: shared types and constants for the spi accelerometer register/fifo block
// no dependencies; used by spi_accel_register_fifo

package sarf_pkg;

  // storage sizes
  localparam int FIFO_DEPTH     = 256;
  localparam int PTR_W          = $clog2(FIFO_DEPTH);
  localparam int SAMPLE_BYTES   = 6;
  localparam int SAMPLE_W       = 8 * SAMPLE_BYTES;
  localparam int SAMPLE_IDX_W   = ($clog2(SAMPLE_BYTES) > 0) ? $clog2(SAMPLE_BYTES) : 1;
  localparam int RESPONSE_BYTES = 16;
  localparam int REG_DEPTH      = 128;
  localparam int REG_ADDR_W     = 7;
  localparam int COUNT_W        = 8;
  localparam int POS_W          = 5;

  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [7:0] WATERMARK_RESET = 8'd16;

  // register map of the device
  localparam logic [REG_ADDR_W-1:0] ADDR_INT_CTRL = 7'h0D;
  localparam logic [REG_ADDR_W-1:0] ADDR_ID       = 7'h0F;
  localparam logic [REG_ADDR_W-1:0] ADDR_CTRL1    = 7'h10;
  localparam logic [REG_ADDR_W-1:0] ADDR_COUNT_LO = 7'h3A;
  localparam logic [REG_ADDR_W-1:0] ADDR_COUNT_HI = 7'h3B;
  localparam logic [REG_ADDR_W-1:0] ADDR_DATA_OUT = 7'h79;

  localparam logic [7:0] ID_VALUE      = 8'h6C;
  localparam logic [7:0] ODR_BITS      = 8'hF0;
  localparam logic [7:0] INT_FIFO_BITS = 8'h38;

  // configuration register index
  localparam logic CFG_WATERMARK = 1'b0;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_HOLD
  } state_t;

endpackage

### design/spi_accel_register_fifo.sv
// spi_accel_register_fifo: spi slave side of an accelerometer with a sample fifo
// depends on sarf_pkg for constants, command codes and state type

// Every request gives exactly one result: the miso byte and the level of the
// int1 line after the request. Frame starts, spi bytes and sample ticks give
// their result without a read state; the second byte of a read frame passes
// through the read state, because the register file and the sample fifo are
// synchronous memories with registered read data. No clearing pass runs after
// reset: register file entries carry valid bits, and the fifo needs none. A
// request is taken while an earlier result still waits at the output; a second
// one waits until that result is taken.

module spi_accel_register_fifo (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  spi_byte,
  input  logic [47:0] sample_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  miso_byte,
  output logic        int1_level,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [7:0] watermark_level;

  // frame and control state
  sarf_pkg::state_t state, state_next;
  logic [sarf_pkg::POS_W-1:0]      frame_position;
  logic [sarf_pkg::REG_ADDR_W-1:0] frame_address;
  logic                            frame_is_read;
  logic [sarf_pkg::SAMPLE_BYTES-1:0][7:0] response;
  logic                            sampling_running;
  logic                            int_enable;
  logic                            int_line;
  logic [sarf_pkg::PTR_W-1:0]      read_pointer;
  logic [sarf_pkg::PTR_W-1:0]      write_pointer;
  logic [sarf_pkg::COUNT_W-1:0]    fifo_count;

  // memories
  logic [7:0] rf_mem [sarf_pkg::REG_DEPTH];
  logic [sarf_pkg::REG_DEPTH-1:0] rf_valid;
  logic [7:0] rf_rdata;
  logic       rf_rd_valid;
  logic [sarf_pkg::SAMPLE_W-1:0] fifo_mem [sarf_pkg::FIFO_DEPTH];
  logic [sarf_pkg::SAMPLE_W-1:0] fifo_rdata;

  // held result while the output register is stalled
  logic [7:0] pend_byte;
  logic       pend_int;

  logic       accept;
  logic       is_frame, is_byte, is_tick;
  logic       rd_issue;
  logic       wr_reg;
  logic       push;
  logic       out_free;
  logic       res_valid;
  logic [7:0] res_byte;
  logic       res_int;
  logic       int_new;
  logic [7:0] read_byte;
  logic [7:0] buf_byte;
  logic [sarf_pkg::POS_W-1:0]    buf_idx;
  logic [sarf_pkg::PTR_W-1:0]    wp_inc;
  logic [sarf_pkg::PTR_W-1:0]    rp_inc;
  logic                          cfg_write;

  // request decode
  assign in_stall = (state != sarf_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_frame = (command == sarf_pkg::CMD_FRAME);
  assign is_byte  = (command == sarf_pkg::CMD_BYTE);
  assign is_tick  = (command == sarf_pkg::CMD_TICK);
  assign rd_issue = accept && is_byte && (frame_position == sarf_pkg::POS_W'(1)) && frame_is_read;
  assign wr_reg   = accept && is_byte && (frame_position == sarf_pkg::POS_W'(1)) && !frame_is_read;
  assign push     = accept && is_tick && sampling_running;
  assign out_free = !out_valid || !out_stall;

  assign wp_inc  = write_pointer + sarf_pkg::PTR_W'(1);
  assign rp_inc  = read_pointer + sarf_pkg::PTR_W'(1);
  assign int_new = int_enable && (sarf_pkg::COUNT_W'(wp_inc) > watermark_level);

  // response buffer byte for the current position (position 0 returns 0)
  assign buf_idx = frame_position - sarf_pkg::POS_W'(1);
  always_comb begin
    buf_byte = 8'h00;
    if (frame_position != '0 && buf_idx < sarf_pkg::POS_W'(sarf_pkg::SAMPLE_BYTES)) begin
      buf_byte = response[buf_idx[sarf_pkg::SAMPLE_IDX_W-1:0]];
    end
  end

  // first response byte of a read access
  always_comb begin
    case (frame_address)
      sarf_pkg::ADDR_ID:       read_byte = sarf_pkg::ID_VALUE;
      sarf_pkg::ADDR_COUNT_LO: read_byte = fifo_count;
      // count bits 9:8 are always zero with an 8-bit count
      sarf_pkg::ADDR_COUNT_HI: read_byte = 8'h00;
      sarf_pkg::ADDR_DATA_OUT: read_byte = fifo_rdata[7:0];
      default:                 read_byte = rf_rd_valid ? rf_rdata : 8'h00;
    endcase
  end

  // next state and result
  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    res_byte   = 8'h00;
    res_int    = int_line;
    case (state)
      sarf_pkg::ST_IDLE: begin
        if (rd_issue) begin
          state_next = sarf_pkg::ST_READ;
        end else if (accept) begin
          res_valid = 1'b1;
          res_byte  = is_byte ? buf_byte : 8'h00;
          res_int   = push ? int_new : int_line;
        end
      end
      sarf_pkg::ST_READ: begin
        res_valid = 1'b1;
        res_byte  = read_byte;
      end
      sarf_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = sarf_pkg::ST_IDLE;
        end
      end
      default: state_next = sarf_pkg::ST_IDLE;
    endcase
    if (res_valid) begin
      state_next = out_free ? sarf_pkg::ST_IDLE : sarf_pkg::ST_HOLD;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sarf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame state, control flags and fifo pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position   <= '0;
      frame_address    <= '0;
      frame_is_read    <= 1'b1;
      response         <= '0;
      sampling_running <= 1'b0;
      int_enable       <= 1'b0;
      int_line         <= 1'b0;
      read_pointer     <= '0;
      write_pointer    <= '0;
      fifo_count       <= '0;
    end else begin
      if (accept && is_frame) begin
        frame_position <= '0;
        frame_address  <= '0;
        frame_is_read  <= 1'b1;
        response       <= '0;
      end
      if (accept && is_byte) begin
        if (frame_position == '0) begin
          frame_address <= spi_byte[sarf_pkg::REG_ADDR_W-1:0];
          frame_is_read <= spi_byte[7];
        end
        if (frame_position != sarf_pkg::POS_MAX) begin
          frame_position <= frame_position + sarf_pkg::POS_W'(1);
        end
      end
      // register write side effects
      if (wr_reg) begin
        if (frame_address == sarf_pkg::ADDR_CTRL1 && (spi_byte & sarf_pkg::ODR_BITS) != 8'h00) begin
          sampling_running <= 1'b1;
        end
        if (frame_address == sarf_pkg::ADDR_INT_CTRL) begin
          int_enable <= (spi_byte & sarf_pkg::INT_FIFO_BITS) != 8'h00;
        end
      end
      // pop on a read of the data-out register
      if (rd_issue && frame_address == sarf_pkg::ADDR_DATA_OUT) begin
        read_pointer <= rp_inc;
        fifo_count   <= sarf_pkg::COUNT_W'(write_pointer - rp_inc);
      end
      // fill the response buffer once the memory data is back
      if (state == sarf_pkg::ST_READ) begin
        if (frame_address == sarf_pkg::ADDR_DATA_OUT) begin
          response <= fifo_rdata;
        end else begin
          response <= sarf_pkg::SAMPLE_W'(read_byte);
        end
      end
      // sample push and interrupt update
      if (push) begin
        write_pointer <= wp_inc;
        fifo_count    <= sarf_pkg::COUNT_W'(wp_inc - read_pointer);
        int_line      <= int_new;
      end
    end
  end

  // register file memory
  always_ff @(posedge clk) begin
    if (wr_reg) begin
      rf_mem[frame_address] <= spi_byte;
    end
    if (rd_issue) begin
      rf_rdata <= rf_mem[frame_address];
    end
  end

  // register file valid bits and registered valid for reads
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid    <= '0;
      rf_rd_valid <= 1'b0;
    end else begin
      if (wr_reg) begin
        rf_valid[frame_address] <= 1'b1;
      end
      if (rd_issue) begin
        rf_rd_valid <= rf_valid[frame_address];
      end
    end
  end

  // sample fifo memory
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[write_pointer] <= sample_data;
    end
    if (rd_issue) begin
      fifo_rdata <= fifo_mem[read_pointer];
    end
  end

  // output register and held result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid || (state == sarf_pkg::ST_HOLD);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == sarf_pkg::ST_HOLD) begin
        miso_byte  <= pend_byte;
        int1_level <= pend_int;
      end else if (res_valid) begin
        miso_byte  <= res_byte;
        int1_level <= res_int;
      end
    end
    if (res_valid && !out_free) begin
      pend_byte <= res_byte;
      pend_int  <= res_int;
    end
  end

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == sarf_pkg::CFG_WATERMARK);
  assign prdata    = (paddr[2] == sarf_pkg::CFG_WATERMARK) ? {24'h0, watermark_level} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      watermark_level <= sarf_pkg::WATERMARK_RESET;
    end else if (cfg_write) begin
      watermark_level <= pwdata[7:0];
    end
  end

endmodule
